[hdl/slu8_pkg.sv]
`default_nettype none

package slu8_pkg;

   typedef struct packed {
      logic [7:0] in_byte;
      logic       in_last;
   } req_type;

   typedef struct packed {
      logic       out_kind;
      logic [7:0] out_byte;
      logic [3:0] status;
      logic       out_last;
   } rsp_type;

   // one accepted byte's worth of work for the output side
   typedef struct packed {
      logic [2:0]      data_count;
      logic [3:0][7:0] data_bytes;
      logic            has_status;
      logic [3:0]      status;
   } cmd_type;

   localparam logic KIND_DATA   = 1'b0;
   localparam logic KIND_STATUS = 1'b1;

   localparam logic [3:0] STATUS_OK       = 4'd0;
   localparam logic [3:0] STATUS_TOKEN    = 4'd1;
   localparam logic [3:0] STATUS_DANGLING = 4'd2;
   localparam logic [3:0] STATUS_BRACE    = 4'd3;
   localparam logic [3:0] STATUS_UNTERM   = 4'd4;
   localparam logic [3:0] STATUS_NONHEX   = 4'd5;
   localparam logic [3:0] STATUS_DIGITS   = 4'd6;
   localparam logic [3:0] STATUS_EMPTY    = 4'd7;
   localparam logic [3:0] STATUS_RANGE    = 4'd8;
   localparam logic [3:0] STATUS_SURR     = 4'd9;
   localparam logic [3:0] STATUS_ESCAPE   = 4'd10;

endpackage

`default_nettype wire

[hdl/slu8_queue.sv]
`default_nettype none

module slu8_queue
   import slu8_pkg::*;
#(
   parameter int DEPTH = 4
) (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    push,
   input  wire cmd_type push_cmd,
   output logic         full,
   input  wire logic    pop,
   output cmd_type      head_cmd,
   output logic         empty
);

   localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   cmd_type            entry_ff [DEPTH];
   logic [IDX_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [IDX_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]   count_ff, count_in;

   assign full     = (count_ff == CNT_W'(DEPTH));
   assign empty    = (count_ff == '0);
   assign head_cmd = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == IDX_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == IDX_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_cmd;
      end
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

`default_nettype wire

[hdl/slu8_front.sv]
`default_nettype none

module slu8_front
   import slu8_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    req_valid,
   output logic         req_stall,
   input  wire req_type req_data,
   output logic         push,
   output cmd_type      push_cmd,
   input  wire logic    q_full
);

   localparam logic [1:0] PHASE_IDLE  = 2'd0;
   localparam logic [1:0] PHASE_ESC   = 2'd1;
   localparam logic [1:0] PHASE_U     = 2'd2;
   localparam logic [1:0] PHASE_BRACE = 2'd3;

   localparam logic [7:0] CHAR_QUOTE  = 8'h22;
   localparam logic [7:0] CHAR_BSLASH = 8'h5C;
   localparam logic [7:0] CHAR_CR     = 8'h0D;
   localparam logic [7:0] CHAR_N      = 8'h6E;
   localparam logic [7:0] CHAR_R      = 8'h72;
   localparam logic [7:0] CHAR_T      = 8'h74;
   localparam logic [7:0] CHAR_ZERO   = 8'h30;
   localparam logic [7:0] CHAR_B      = 8'h62;
   localparam logic [7:0] CHAR_F      = 8'h66;
   localparam logic [7:0] CHAR_U      = 8'h75;
   localparam logic [7:0] CHAR_LBRACE = 8'h7B;
   localparam logic [7:0] CHAR_RBRACE = 8'h7D;

   logic [7:0]  held_ff, held_in;
   logic        held_valid_ff, held_valid_in;
   logic [1:0]  seen_ff, seen_in;
   logic [1:0]  phase_ff, phase_in;
   logic [23:0] cp_ff, cp_in;
   logic [2:0]  digits_ff, digits_in;
   logic [3:0]  err_ff, err_in;

   logic            accept;
   logic            first;
   logic            is_last;
   logic            feed_en;
   logic            bad_form;
   logic [3:0]      end_err;
   logic            has_status;
   logic [3:0]      status;

   logic            hex_ok;
   logic [3:0]      hex_val;
   logic [2:0]      enc_count;
   logic [3:0][7:0] enc_bytes;

   logic [2:0]      f_count;
   logic [3:0][7:0] f_bytes;
   logic [1:0]      f_phase;
   logic [23:0]     f_cp;
   logic [2:0]      f_digits;
   logic [3:0]      f_err;

   assign req_stall = q_full;
   assign accept    = req_valid && !req_stall;
   assign first     = (seen_ff == 2'd0);
   assign is_last   = req_data.in_last;
   assign feed_en   = !first && held_valid_ff && !(is_last && req_data.in_byte == CHAR_CR);

   always_comb begin
      hex_ok  = 1'b1;
      hex_val = held_ff[3:0];
      if (held_ff >= 8'h30 && held_ff <= 8'h39) begin
         hex_val = held_ff[3:0];
      end else if ((held_ff >= 8'h61 && held_ff <= 8'h66) ||
                   (held_ff >= 8'h41 && held_ff <= 8'h46)) begin
         hex_val = held_ff[3:0] + 4'd9;
      end else begin
         hex_ok = 1'b0;
      end
   end

   always_comb begin
      enc_bytes = '0;
      if (cp_ff <= 24'h00007F) begin
         enc_count    = 3'd1;
         enc_bytes[0] = cp_ff[7:0];
      end else if (cp_ff <= 24'h0007FF) begin
         enc_count    = 3'd2;
         enc_bytes[0] = {3'b110, cp_ff[10:6]};
         enc_bytes[1] = {2'b10, cp_ff[5:0]};
      end else if (cp_ff <= 24'h00FFFF) begin
         enc_count    = 3'd3;
         enc_bytes[0] = {4'b1110, cp_ff[15:12]};
         enc_bytes[1] = {2'b10, cp_ff[11:6]};
         enc_bytes[2] = {2'b10, cp_ff[5:0]};
      end else begin
         enc_count    = 3'd4;
         enc_bytes[0] = {5'b11110, cp_ff[20:18]};
         enc_bytes[1] = {2'b10, cp_ff[17:12]};
         enc_bytes[2] = {2'b10, cp_ff[11:6]};
         enc_bytes[3] = {2'b10, cp_ff[5:0]};
      end
   end

   // content decode of the held byte
   always_comb begin
      f_count  = 3'd0;
      f_bytes  = '0;
      f_phase  = phase_ff;
      f_cp     = cp_ff;
      f_digits = digits_ff;
      f_err    = err_ff;
      if (feed_en && err_ff == STATUS_OK) begin
         case (phase_ff)
            PHASE_IDLE: begin
               if (held_ff == CHAR_BSLASH) begin
                  f_phase = PHASE_ESC;
               end else begin
                  f_count    = 3'd1;
                  f_bytes[0] = held_ff;
               end
            end
            PHASE_ESC: begin
               f_phase = PHASE_IDLE;
               f_count = 3'd1;
               case (held_ff)
                  CHAR_QUOTE:  f_bytes[0] = 8'h22;
                  CHAR_BSLASH: f_bytes[0] = 8'h5C;
                  CHAR_N:      f_bytes[0] = 8'h0A;
                  CHAR_R:      f_bytes[0] = 8'h0D;
                  CHAR_T:      f_bytes[0] = 8'h09;
                  CHAR_ZERO:   f_bytes[0] = 8'h00;
                  CHAR_B:      f_bytes[0] = 8'h08;
                  CHAR_F:      f_bytes[0] = 8'h0C;
                  CHAR_U: begin
                     f_count = 3'd0;
                     f_phase = PHASE_U;
                  end
                  default: begin
                     f_count = 3'd0;
                     f_err   = STATUS_ESCAPE;
                  end
               endcase
            end
            PHASE_U: begin
               if (held_ff == CHAR_LBRACE) begin
                  f_phase  = PHASE_BRACE;
                  f_cp     = '0;
                  f_digits = '0;
               end else begin
                  f_err = STATUS_BRACE;
               end
            end
            default: begin
               if (held_ff == CHAR_RBRACE) begin
                  f_phase = PHASE_IDLE;
                  if (digits_ff == 3'd0) begin
                     f_err = STATUS_EMPTY;
                  end else if (cp_ff > 24'h10FFFF) begin
                     f_err = STATUS_RANGE;
                  end else if (cp_ff >= 24'h00D800 && cp_ff <= 24'h00DFFF) begin
                     f_err = STATUS_SURR;
                  end else begin
                     f_count = enc_count;
                     f_bytes = enc_bytes;
                  end
               end else if (!hex_ok) begin
                  f_err = STATUS_NONHEX;
               end else if (digits_ff >= 3'd6) begin
                  f_err = STATUS_DIGITS;
               end else begin
                  f_cp     = {cp_ff[19:0], hex_val};
                  f_digits = digits_ff + 3'd1;
               end
            end
         endcase
      end
   end

   always_comb begin
      bad_form = 1'b1;
      end_err  = f_err;
      if (req_data.in_byte == CHAR_CR) begin
         bad_form = !(seen_ff == 2'd2 && held_valid_ff && held_ff == CHAR_QUOTE);
      end else begin
         bad_form = (req_data.in_byte != CHAR_QUOTE);
      end
      if (f_err == STATUS_OK) begin
         case (f_phase)
            PHASE_ESC:   end_err = STATUS_DANGLING;
            PHASE_U:     end_err = STATUS_BRACE;
            PHASE_BRACE: end_err = STATUS_UNTERM;
            default:     end_err = STATUS_OK;
         endcase
      end
   end

   always_comb begin
      held_in       = req_data.in_byte;
      held_valid_in = 1'b1;
      seen_in       = (seen_ff == 2'd2) ? 2'd2 : seen_ff + 2'd1;
      phase_in      = f_phase;
      cp_in         = f_cp;
      digits_in     = f_digits;
      err_in        = f_err;
      has_status    = 1'b0;
      status        = STATUS_OK;
      if (first) begin
         held_in       = held_ff;
         held_valid_in = held_valid_ff;
         seen_in       = 2'd1;
         if (req_data.in_byte != CHAR_QUOTE) begin
            err_in = STATUS_TOKEN;
         end
         if (is_last) begin
            has_status = 1'b1;
            status     = STATUS_TOKEN;
         end
      end else if (is_last) begin
         has_status = 1'b1;
         status     = bad_form ? STATUS_TOKEN : end_err;
      end
      if (is_last) begin
         held_in       = '0;
         held_valid_in = 1'b0;
         seen_in       = 2'd0;
         phase_in      = PHASE_IDLE;
         cp_in         = '0;
         digits_in     = '0;
         err_in        = STATUS_OK;
      end
   end

   assign push_cmd.data_count = f_count;
   assign push_cmd.data_bytes = f_bytes;
   assign push_cmd.has_status = has_status;
   assign push_cmd.status     = status;
   assign push               = accept && (f_count != 3'd0 || has_status);

   always_ff @(posedge clock) begin
      if (reset) begin
         held_ff       <= '0;
         held_valid_ff <= 1'b0;
         seen_ff       <= 2'd0;
         phase_ff      <= PHASE_IDLE;
         cp_ff         <= '0;
         digits_ff     <= '0;
         err_ff        <= STATUS_OK;
      end else if (accept) begin
         held_ff       <= held_in;
         held_valid_ff <= held_valid_in;
         seen_ff       <= seen_in;
         phase_ff      <= phase_in;
         cp_ff         <= cp_in;
         digits_ff     <= digits_in;
         err_ff        <= err_in;
      end
   end

endmodule

`default_nettype wire

[hdl/slu8_back.sv]
`default_nettype none

module slu8_back
   import slu8_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire cmd_type head_cmd,
   input  wire logic    q_empty,
   output logic         pop,
   output logic         rsp_valid,
   input  wire logic    rsp_stall,
   output rsp_type      rsp_data
);

   logic       rsp_valid_ff;
   rsp_type    rsp_data_ff, rsp_data_in;
   logic [2:0] idx_ff, idx_in;
   logic [2:0] total;
   logic       load;
   logic       final_item;

   assign total      = head_cmd.data_count + {2'b00, head_cmd.has_status};
   assign load       = !q_empty && (!rsp_valid_ff || !rsp_stall);
   assign final_item = ((idx_ff + 3'd1) == total);
   assign pop        = load && final_item;
   assign idx_in     = final_item ? 3'd0 : idx_ff + 3'd1;

   always_comb begin
      if (idx_ff < head_cmd.data_count) begin
         rsp_data_in.out_kind = KIND_DATA;
         rsp_data_in.out_byte = head_cmd.data_bytes[idx_ff[1:0]];
         rsp_data_in.status   = STATUS_OK;
         rsp_data_in.out_last = 1'b0;
      end else begin
         rsp_data_in.out_kind = KIND_STATUS;
         rsp_data_in.out_byte = 8'h00;
         rsp_data_in.status   = head_cmd.status;
         rsp_data_in.out_last = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         rsp_data_ff <= rsp_data_in;
      end
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         idx_ff       <= 3'd0;
      end else if (load) begin
         rsp_valid_ff <= 1'b1;
         idx_ff       <= idx_in;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

`default_nettype wire

[hdl/string_literal_unescape_utf8.sv]
`default_nettype none

// channel  | ports                          | payload
// req      | req_valid, req_stall, req_data | in_byte, in_last
// rsp      | rsp_valid, rsp_stall, rsp_data | out_kind, out_byte, status, out_last
//
// One token byte is taken per cycle while the command queue has room.
// The output stage sends one result per cycle while rsp_stall is low: a \u escape
// gives 1 to 4 results there (one per UTF-8 byte), and the end-of-token status one more.
// Synchronous active-high reset clears decoder state, queue and output valid.
// req_stall is high only while the command queue is full.

module string_literal_unescape_utf8
   import slu8_pkg::*;
#(
   parameter int QUEUE_DEPTH = 4
) (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    req_valid,
   output logic         req_stall,
   input  wire req_type req_data,
   output logic         rsp_valid,
   input  wire logic    rsp_stall,
   output rsp_type      rsp_data
);

   logic    q_push;
   cmd_type q_push_cmd;
   logic    q_full;
   logic    q_pop;
   cmd_type q_head;
   logic    q_empty;

   slu8_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .push      (q_push),
      .push_cmd  (q_push_cmd),
      .q_full    (q_full)
   );

   slu8_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (q_push),
      .push_cmd (q_push_cmd),
      .full     (q_full),
      .pop      (q_pop),
      .head_cmd (q_head),
      .empty    (q_empty)
   );

   slu8_back u_back (
      .clock     (clock),
      .reset     (reset),
      .head_cmd  (q_head),
      .q_empty   (q_empty),
      .pop       (q_pop),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   a_status_form: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.out_kind == KIND_STATUS) |->
         (rsp_data.out_last && rsp_data.out_byte == 8'h00))
      else $error("status transfer malformed");

   a_data_form: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.out_kind == KIND_DATA) |->
         (!rsp_data.out_last && rsp_data.status == STATUS_OK))
      else $error("data transfer malformed");

   a_push_visible: assert property (@(posedge clock) disable iff (reset)
      q_push |=> !q_empty)
      else $error("queue lost a command");

   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("output valid after reset");

endmodule

`default_nettype wire

[tb/sv/tb.sv]
`timescale 1ns / 1ps

module tb;
   import slu8_pkg::*;

   typedef enum logic [1:0] {ESC_IDLE, ESC_SLASH, ESC_U, ESC_BRACE} esc_state_type;
   typedef logic [7:0] byte_q_type[$];

   localparam logic [7:0] CH_QUOTE  = 8'h22;
   localparam logic [7:0] CH_BSLASH = 8'h5C;
   localparam logic [7:0] CH_CR     = 8'h0D;
   localparam logic [7:0] CH_LBRACE = 8'h7B;
   localparam logic [7:0] CH_RBRACE = 8'h7D;

   localparam int IDLE_MAX       = 6;
   localparam int HOLD_CYCLES    = 300;
   localparam int WATCHDOG_LIMIT = 2000;
   localparam int TAIL_CYCLES    = 20;
   localparam int RANDOM_ITEMS   = 395;

   localparam string ESC_CHARS = "\"\\nrt0bf";
   localparam string ODD_CHARS = "aqxzU8{ ";
   localparam logic [23:0] EDGE_CP [10] = '{24'h0, 24'h7F, 24'h80, 24'h7FF, 24'h800,
                                            24'hD7FF, 24'hE000, 24'hFFFF, 24'h10000,
                                            24'h10FFFF};

   logic    clock     = 1'b0;
   logic    reset     = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_stall;
   req_type req_data  = '0;
   logic    rsp_valid;
   logic    rsp_stall = 1'b0;
   rsp_type rsp_data;

   string_literal_unescape_utf8 dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // decoder state mirror
   logic [7:0]    tok_held    = '0;
   logic          tok_held_ok = 1'b0;
   logic [1:0]    tok_count   = '0;
   esc_state_type esc_state   = ESC_IDLE;
   logic [23:0]   cp_acc      = '0;
   logic [2:0]    digit_cnt   = '0;
   logic [3:0]    tok_err     = STATUS_OK;

   rsp_type    pending_out[$];
   byte_q_type tok_buf;
   int         errors       = 0;
   int         bytes_sent   = 0;
   int         idle_cycles  = 0;
   int         stall_left   = 0;
   bit         tx_idle      = 1'b0;
   bit         rx_idle      = 1'b0;
   bit         hold_request = 1'b0;

   function void clear_token();
      tok_held    = '0;
      tok_held_ok = 1'b0;
      tok_count   = '0;
      esc_state   = ESC_IDLE;
      cp_acc      = '0;
      digit_cnt   = '0;
      tok_err     = STATUS_OK;
   endfunction

   function void push_data(logic [7:0] b);
      pending_out.insert(pending_out.size(), rsp_type'{out_kind: KIND_DATA, out_byte: b,
                                                       status: STATUS_OK, out_last: 1'b0});
   endfunction

   function void push_status(logic [3:0] st);
      pending_out.insert(pending_out.size(), rsp_type'{out_kind: KIND_STATUS,
                                                       out_byte: 8'h00, status: st,
                                                       out_last: 1'b1});
   endfunction

   function automatic int nibble_of(logic [7:0] c);
      if (c >= "0" && c <= "9") return int'(c - 8'h30);
      if (c >= "a" && c <= "f") return int'(c - 8'h61) + 10;
      if (c >= "A" && c <= "F") return int'(c - 8'h41) + 10;
      return -1;
   endfunction

   function void put_utf8(logic [23:0] cp);
      if (cp <= 24'h7F) begin
         push_data(cp[7:0]);
      end else if (cp <= 24'h7FF) begin
         push_data({3'b110, cp[10:6]});
         push_data({2'b10, cp[5:0]});
      end else if (cp <= 24'hFFFF) begin
         push_data({4'b1110, cp[15:12]});
         push_data({2'b10, cp[11:6]});
         push_data({2'b10, cp[5:0]});
      end else begin
         push_data({5'b11110, cp[20:18]});
         push_data({2'b10, cp[17:12]});
         push_data({2'b10, cp[11:6]});
         push_data({2'b10, cp[5:0]});
      end
   endfunction

   function void decode_content(logic [7:0] c);
      int v;
      if (tok_err != STATUS_OK) return;
      case (esc_state)
         ESC_IDLE: begin
            if (c == CH_BSLASH) esc_state = ESC_SLASH;
            else push_data(c);
         end
         ESC_SLASH: begin
            esc_state = ESC_IDLE;
            case (c)
               CH_QUOTE, CH_BSLASH: push_data(c);
               "n": push_data(8'h0A);
               "r": push_data(8'h0D);
               "t": push_data(8'h09);
               "0": push_data(8'h00);
               "b": push_data(8'h08);
               "f": push_data(8'h0C);
               "u": esc_state = ESC_U;
               default: tok_err = STATUS_ESCAPE;
            endcase
         end
         ESC_U: begin
            if (c == CH_LBRACE) begin
               esc_state = ESC_BRACE;
               cp_acc    = '0;
               digit_cnt = '0;
            end else begin
               tok_err = STATUS_BRACE;
            end
         end
         default: begin
            if (c == CH_RBRACE) begin
               if (digit_cnt == 0) tok_err = STATUS_EMPTY;
               else if (cp_acc > 24'h10FFFF) tok_err = STATUS_RANGE;
               else if (cp_acc >= 24'hD800 && cp_acc <= 24'hDFFF) tok_err = STATUS_SURR;
               else put_utf8(cp_acc);
               esc_state = ESC_IDLE;
            end else begin
               v = nibble_of(c);
               if (v < 0) begin
                  tok_err = STATUS_NONHEX;
               end else if (digit_cnt >= 6) begin
                  tok_err = STATUS_DIGITS;
               end else begin
                  cp_acc    = {cp_acc[19:0], 4'(v)};
                  digit_cnt = digit_cnt + 3'd1;
               end
            end
         end
      endcase
   endfunction

   function void decode_byte(req_type r);
      logic bad;
      if (tok_count == 0) begin
         if (r.in_byte != CH_QUOTE) tok_err = STATUS_TOKEN;
         if (r.in_last) begin
            push_status(STATUS_TOKEN);
            clear_token();
         end else begin
            tok_count = 2'd1;
         end
         return;
      end
      if (!r.in_last) begin
         if (tok_held_ok) decode_content(tok_held);
         tok_held    = r.in_byte;
         tok_held_ok = 1'b1;
         if (tok_count < 2) tok_count = tok_count + 2'd1;
         return;
      end
      // trailing CR: the held byte must be the closing quote
      if (r.in_byte == CH_CR) begin
         bad = !(tok_count == 2 && tok_held_ok && tok_held == CH_QUOTE);
      end else begin
         if (tok_held_ok) decode_content(tok_held);
         bad = (r.in_byte != CH_QUOTE);
      end
      if (tok_err == STATUS_OK) begin
         case (esc_state)
            ESC_SLASH: tok_err = STATUS_DANGLING;
            ESC_U:     tok_err = STATUS_BRACE;
            ESC_BRACE: tok_err = STATUS_UNTERM;
            default:   ;
         endcase
      end
      push_status(bad ? STATUS_TOKEN : tok_err);
      clear_token();
   endfunction

   function void check_field(string name, logic [7:0] want, logic [7:0] got);
      if (got !== want) begin
         $error("%s: expected %0h, got %0h", name, want, got);
         errors++;
      end
   endfunction

   // transfer monitor, scoreboard and watchdog
   always @(posedge clock) begin
      rsp_type want;
      if (!reset) begin
         if (req_valid && !req_stall) decode_byte(req_data);
         if (rsp_valid && !rsp_stall) begin
            if (pending_out.size() == 0) begin
               $error("unexpected result: kind %0d byte %0h status %0d last %0d",
                      rsp_data.out_kind, rsp_data.out_byte, rsp_data.status,
                      rsp_data.out_last);
               errors++;
            end else begin
               want = pending_out.pop_front();
               check_field("out_kind", 8'(want.out_kind), 8'(rsp_data.out_kind));
               check_field("out_byte", want.out_byte, rsp_data.out_byte);
               check_field("status", 8'(want.status), 8'(rsp_data.status));
               check_field("out_last", 8'(want.out_last), 8'(rsp_data.out_last));
            end
         end
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
            idle_cycles = 0;
         end else begin
            idle_cycles++;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
               $display("[FAIL] regression broken");
               $finish;
            end
         end
      end
   end

   // result side stalls
   always @(posedge clock) begin
      if (!reset) begin
         if (hold_request) begin
            hold_request = 1'b0;
            stall_left   = HOLD_CYCLES;
         end else if (rsp_valid && !rsp_stall) begin
            stall_left = rx_idle ? $urandom_range(0, IDLE_MAX) : 0;
         end
         if (stall_left > 0) begin
            rsp_stall <= 1'b1;
            stall_left--;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   task automatic send_byte(logic [7:0] b, logic last);
      int gap;
      gap = tx_idle ? $urandom_range(0, IDLE_MAX) : 0;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= '{in_byte: b, in_last: last};
      do @(posedge clock); while (req_stall);
      bytes_sent++;
   endtask

   task automatic send_token(byte_q_type bytes);
      foreach (bytes[i]) send_byte(bytes[i], i == bytes.size() - 1);
   endtask

   task automatic send_text(string s, bit with_cr);
      byte_q_type bytes;
      for (int i = 0; i < s.len(); i++) bytes.insert(bytes.size(), s[i]);
      if (with_cr) bytes.insert(bytes.size(), CH_CR);
      send_token(bytes);
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_out.size() != 0) @(posedge clock);
   endtask

   function void append_byte(logic [7:0] b);
      tok_buf.insert(tok_buf.size(), b);
   endfunction

   function void push_text(string s);
      for (int i = 0; i < s.len(); i++) append_byte(s[i]);
   endfunction

   function automatic int min_digits(logic [31:0] cp);
      int n;
      n = 1;
      while (n < 8 && (cp >> (4 * n)) != 0) n++;
      return n;
   endfunction

   // \u{...} with mixed-case digits, zero padded to ndig
   function void push_u(logic [31:0] cp, int ndig);
      logic [3:0] nib;
      push_text("\\u{");
      for (int i = ndig - 1; i >= 0; i--) begin
         nib = cp[4 * i +: 4];
         if (nib < 10) append_byte(8'h30 + 8'(nib));
         else append_byte(($urandom_range(0, 1) ? 8'h61 : 8'h41) + 8'(nib) - 8'd10);
      end
      push_text("}");
   endfunction

   function void add_piece();
      logic [31:0] cp;
      logic [7:0]  b;
      int          sel;
      sel = $urandom_range(0, 99);
      if (sel < 40) begin
         b = 8'($urandom);
         append_byte(b);
         if (b == CH_BSLASH) append_byte(b);
      end else if (sel < 58) begin
         push_text("\\");
         append_byte(ESC_CHARS[$urandom_range(0, 7)]);
      end else if (sel < 85) begin
         case ($urandom_range(0, 4))
            0: cp = $urandom_range(0, 'h7F);
            1: cp = $urandom_range('h80, 'h7FF);
            2: cp = $urandom_range(0, 1) ? $urandom_range('h800, 'hD7FF)
                                         : $urandom_range('hE000, 'hFFFF);
            3: cp = $urandom_range('h10000, 'h10FFFF);
            default: cp = 32'(EDGE_CP[$urandom_range(0, 9)]);
         endcase
         push_u(cp, $urandom_range(min_digits(cp), 6));
      end else begin
         case ($urandom_range(0, 6))
            0: begin
               push_text("\\");
               append_byte(ODD_CHARS[$urandom_range(0, 7)]);
            end
            1: push_text("\\ux");
            2: push_text("\\u{}");
            3: push_text("\\u{1g}");
            4: begin
               cp = $urandom;
               push_u(cp, 7);
            end
            5: begin
               cp = $urandom_range('h110000, 'hFFFFFF);
               push_u(cp, 6);
            end
            default: begin
               cp = $urandom_range('hD800, 'hDFFF);
               push_u(cp, $urandom_range(4, 6));
            end
         endcase
      end
   endfunction

   function void build_token();
      int         form;
      logic [7:0] b;
      tok_buf.delete();
      form = $urandom_range(0, 99);
      if (form < 4) begin
         do b = 8'($urandom); while (b == CH_QUOTE);
         append_byte(b);
      end else begin
         append_byte(CH_QUOTE);
      end
      if (form >= 4 && form < 8) return;
      repeat ($urandom_range(0, 5)) add_piece();
      // end of token inside an escape
      if (form >= 8 && form < 16) begin
         case ($urandom_range(0, 2))
            0: push_text("\\");
            1: push_text("\\u");
            default: push_text("\\u{a");
         endcase
      end
      if (form >= 16 && form < 20) begin
         do b = 8'($urandom); while (b == CH_QUOTE);
         append_byte(b);
      end else begin
         append_byte(CH_QUOTE);
      end
      if ($urandom_range(0, 4) == 0) append_byte(CH_CR);
   endfunction

   task automatic test_token_form();
      tx_idle = 1'b1;
      rx_idle = 1'b1;
      send_text("\"", 1'b0);
      send_text("\"\"", 1'b1);
      send_text("\"\\qx", 1'b0);
   endtask

   task automatic test_escape_ends();
      send_text("\"\\u{10FFFF}\"", 1'b0);
      send_text("\"\\\"", 1'b0);
      send_text("\"\\u\"", 1'b0);
   endtask

   task automatic test_backpressure();
      tx_idle      = 1'b0;
      hold_request = 1'b1;
      send_text("\"\\u{10FFFF}ab\\u{7ff}\\u{FFFF}cd\\u{1F600}\\u{41}\\t\"", 1'b0);
      drain();
   endtask

   task automatic test_random();
      int stop_at;
      stop_at = bytes_sent + RANDOM_ITEMS;
      while (bytes_sent < stop_at) begin
         tx_idle = $urandom_range(0, 3) != 0;
         rx_idle = $urandom_range(0, 3) != 0;
         build_token();
         send_token(tok_buf);
      end
   endtask

   initial begin
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      test_token_form();
      test_escape_ends();
      test_backpressure();
      test_random();
      drain();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (pending_out.size() != 0) begin
         $error("results missing: %0d still expected", pending_out.size());
         errors++;
      end
      if (errors == 0) $display("[ OK ] regression clean");
      else $display("[FAIL] regression broken");
      $finish;
   end

endmodule

[files.f]
hdl/slu8_pkg.sv
hdl/slu8_queue.sv
hdl/slu8_front.sv
hdl/slu8_back.sv
hdl/string_literal_unescape_utf8.sv
tb/sv/tb.sv
